### rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Shared constants, codes, state encoding and word-level helper functions.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
  localparam int unsigned WORD_W       = 32;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

  localparam logic [WORD_W-1:0] RESET_SEED    = 32'd5489;
  localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A      = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TOP_BIT_MASK  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B      = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C      = 32'hefc6_0000;

  // Command codes carried on the request channel.
  localparam logic CMD_NEXT = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_IDLE,
    ST_TWIST
  } mtp_state_t;

  // One write port and two read ports on the state memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mtp_ram_req_t;

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] pair;
    logic [WORD_W-1:0] mixed;
    pair  = (cur & TOP_BIT_MASK) | (nxt & LOW_BITS_MASK);
    mixed = pair >> 1;
    if (pair[0]) begin
      mixed = mixed ^ MATRIX_A;
    end
    return far ^ mixed;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v_in);
    logic [WORD_W-1:0] v;
    v = v_in;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

### rtl/mtp_req_if.sv
// ----------------------------------------------------------------------------
// MT19937 request channel
// Valid/ready channel carrying a command and a seed word per beat.
// ----------------------------------------------------------------------------
interface mtp_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] seed;

  modport source (output valid, output command, output seed, input ready);
  modport sink   (input valid, input command, input seed, output ready);
endinterface

### rtl/mtp_rsp_if.sv
// ----------------------------------------------------------------------------
// MT19937 result channel
// Valid/ready channel carrying one tempered random word per beat.
// ----------------------------------------------------------------------------
interface mtp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

### rtl/mtp_state_ram.sv
// ----------------------------------------------------------------------------
// MT19937 state memory
// 624 x 32 synchronous memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtp_state_ram (
  input  logic                       clk,
  input  mtp_pkg::mtp_ram_req_t      req,
  output logic [mtp_pkg::WORD_W-1:0] rd_a,
  output logic [mtp_pkg::WORD_W-1:0] rd_b
);

  logic [mtp_pkg::WORD_W-1:0] mem [mtp_pkg::STATE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds while no read is issued, so a stalled twist keeps its operands.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a <= mem[req.raddr_a];
      rd_b <= mem[req.raddr_b];
    end
  end

endmodule

### rtl/mtp_engine.sv
// ----------------------------------------------------------------------------
// MT19937 sequencer and datapath
// Seeds the state memory word by word and twists one word in place per output.
// ----------------------------------------------------------------------------
module mtp_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [mtp_pkg::WORD_W-1:0] in_seed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mtp_pkg::WORD_W-1:0] out_word,
  output mtp_pkg::mtp_ram_req_t      ram_req,
  input  logic [mtp_pkg::WORD_W-1:0] rd_a,
  input  logic [mtp_pkg::WORD_W-1:0] rd_b
);

  localparam int unsigned AW = mtp_pkg::ADDR_W;
  localparam int unsigned WW = mtp_pkg::WORD_W;

  mtp_pkg::mtp_state_t state, state_next;

  logic [AW-1:0] pos;       // position of the next word to twist and emit
  logic [AW-1:0] idx;       // seeding index
  logic [WW-1:0] prev;      // last seeded word
  logic [WW-1:0] prod;      // registered seeding product
  logic [WW-1:0] cur;       // untwisted word at pos, carried from the previous read

  logic          accept;
  logic          out_free;
  logic [AW-1:0] pos_inc;
  logic [AW:0]   far_sum;
  logic [AW-1:0] far_addr;
  logic [WW-1:0] twisted;
  logic [WW-1:0] seed_word;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pos_inc  = (pos == mtp_pkg::LAST_ADDR) ? '0 : pos + 1'b1;
  assign far_sum  = {1'b0, pos} + (AW+1)'(mtp_pkg::TWIST_OFFSET);
  assign far_addr = (far_sum >= (AW+1)'(mtp_pkg::STATE_WORDS))
                    ? AW'(far_sum - (AW+1)'(mtp_pkg::STATE_WORDS))
                    : AW'(far_sum);
  assign twisted   = mtp_pkg::twist_word(cur, rd_a, rd_b);
  assign seed_word = prod + {{(WW-AW){1'b0}}, idx};

  always_comb begin
    state_next = state;
    case (state)
      mtp_pkg::ST_INIT:     state_next = mtp_pkg::ST_SEED_MUL;
      mtp_pkg::ST_SEED_MUL: state_next = mtp_pkg::ST_SEED_ADD;
      mtp_pkg::ST_SEED_ADD: begin
        state_next = (idx == mtp_pkg::LAST_ADDR) ? mtp_pkg::ST_IDLE : mtp_pkg::ST_SEED_MUL;
      end
      mtp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_command == mtp_pkg::CMD_SEED) ? mtp_pkg::ST_SEED_MUL
                                                         : mtp_pkg::ST_TWIST;
        end
      end
      mtp_pkg::ST_TWIST: begin
        if (out_free) begin
          state_next = mtp_pkg::ST_IDLE;
        end
      end
      default: state_next = mtp_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready        = (state == mtp_pkg::ST_IDLE);
    ram_req.we      = 1'b0;
    ram_req.waddr   = '0;
    ram_req.wdata   = '0;
    ram_req.rd_en   = 1'b0;
    ram_req.raddr_a = pos_inc;
    ram_req.raddr_b = far_addr;
    case (state)
      mtp_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = mtp_pkg::RESET_SEED;
      end
      mtp_pkg::ST_SEED_ADD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx;
        ram_req.wdata = seed_word;
      end
      mtp_pkg::ST_IDLE: begin
        if (accept && in_command == mtp_pkg::CMD_SEED) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = in_seed;
        end
        ram_req.rd_en = accept && (in_command == mtp_pkg::CMD_NEXT);
      end
      mtp_pkg::ST_TWIST: begin
        ram_req.we    = out_free;
        ram_req.waddr = pos;
        ram_req.wdata = twisted;
      end
      default: ram_req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtp_pkg::ST_INIT;
      out_valid <= 1'b0;
      pos       <= '0;
      idx       <= '0;
    end else begin
      state <= state_next;
      // A new word may replace the one being taken in the same cycle.
      if (state == mtp_pkg::ST_TWIST && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        mtp_pkg::ST_INIT: begin
          prev <= mtp_pkg::RESET_SEED;
          cur  <= mtp_pkg::RESET_SEED;
          idx  <= AW'(1);
        end
        mtp_pkg::ST_SEED_MUL: begin
          prod <= WW'(mtp_pkg::SEED_MULT * (prev ^ (prev >> 30)));
        end
        mtp_pkg::ST_SEED_ADD: begin
          prev <= seed_word;
          idx  <= idx + 1'b1;
          if (idx == mtp_pkg::LAST_ADDR) begin
            pos <= '0;
          end
        end
        mtp_pkg::ST_IDLE: begin
          if (accept && in_command == mtp_pkg::CMD_SEED) begin
            prev <= in_seed;
            cur  <= in_seed;
            idx  <= AW'(1);
          end
        end
        mtp_pkg::ST_TWIST: begin
          if (out_free) begin
            out_word  <= mtp_pkg::temper(twisted);
            cur       <= rd_a;
            pos       <= pos_inc;
          end
        end
        default: begin
          idx <= '0;
        end
      endcase
    end
  end

endmodule

### rtl/mersenne_twister_prng.sv
// A next beat reads the state memory when accepted; the twist state then registers the
//   tempered word, and waits while the previous result is still held. A new beat is
//   taken only after the two-port read and the in-place twist write of the same word.
// A reseed beat gives no result and keeps the block busy while it seeds the other words.
// After reset the block seeds itself with 5489 and takes no beat until seeding is done.
// ----------------------------------------------------------------------------
// MT19937 pseudo-random generator
// 32-bit Mersenne Twister with reseed command and tempered word output.
// ----------------------------------------------------------------------------
module mersenne_twister_prng (
  input logic        clk,
  input logic        rst,
  mtp_req_if.sink    request,
  mtp_rsp_if.source  result
);

  mtp_pkg::mtp_ram_req_t      ram_req;
  logic [mtp_pkg::WORD_W-1:0] rd_a;
  logic [mtp_pkg::WORD_W-1:0] rd_b;

  mtp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .in_command (request.command),
    .in_seed    (request.seed),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_word   (result.random_word),
    .ram_req    (ram_req),
    .rd_a       (rd_a),
    .rd_b       (rd_b)
  );

  mtp_state_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule

### rtl/mtp_checker.sv
// ----------------------------------------------------------------------------
// MT19937 port checker
// Watches the generator's channels for ordering and timing slips.
// ----------------------------------------------------------------------------
module mtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_command,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_word
);

  logic next_beat;
  logic seed_beat;

  assign next_beat = req_valid && req_ready && (req_command == mtp_pkg::CMD_NEXT);
  assign seed_beat = req_valid && req_ready && (req_command == mtp_pkg::CMD_SEED);

  // The power-on seeding pass keeps the request side closed.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready high straight after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("stalled result beat changed or vanished");

  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    seed_beat && !rsp_valid |=> !rsp_valid)
    else $error("reseed beat produced a result");

  a_next_latency: assert property (@(posedge clk) disable iff (rst)
    next_beat && !rsp_valid |-> ##2 rsp_valid)
    else $error("next beat did not give a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(next_beat, 2))
    else $error("result appeared without a next beat");

endmodule

bind mersenne_twister_prng mtp_checker u_mtp_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_word    (result.random_word)
);
